[design/rwf_pkg.sv]
// Shared constants, types and the arctangent table of the right-wall follow controller.
`timescale 1ns / 1ps
`default_nettype none
package rwf_pkg;

  localparam int SEARCH_SPEED_DEF      = 100;
  localparam int SEARCH_TURN_SPEED_DEF = 300;
  localparam int SCAN_TIMEOUT_MS_DEF   = 500;
  localparam int CORDIC_STEPS_DEF      = 16;
  localparam int ATAN_ENTRIES          = 24;
  localparam int SQRT2_Q12             = 5793;

  // Divider operand widths: the largest numerator is right*x*256 plus rounding.
  localparam int DIV_NW = 53;
  localparam int DIV_DW = 31;

  localparam logic [1:0] MODE_WAIT   = 2'd0;
  localparam logic [1:0] MODE_TURN   = 2'd1;
  localparam logic [1:0] MODE_FIND   = 2'd2;
  localparam logic [1:0] MODE_FOLLOW = 2'd3;

  localparam logic [2:0] REG_WALL_DISTANCE = 3'd0;
  localparam logic [2:0] REG_FRONT_STOP    = 3'd1;
  localparam logic [2:0] REG_FRONT_RELEASE = 3'd2;
  localparam logic [2:0] REG_LOST_WALL     = 3'd3;
  localparam logic [2:0] REG_FORWARD_SPEED = 3'd4;
  localparam logic [2:0] REG_TURN_SPEED    = 3'd5;
  localparam logic [2:0] REG_DISTANCE_GAIN = 3'd6;
  localparam logic [2:0] REG_HEADING_GAIN  = 3'd7;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
  } div_rsp_t;

  // Arctangent of 2^-i in Q16 radians.
  function automatic logic [16:0] atan_q16(input logic [4:0] i);
    logic [16:0] r;
    case (i)
      5'd0:  r = 17'd51472;
      5'd1:  r = 17'd30385;
      5'd2:  r = 17'd16055;
      5'd3:  r = 17'd8150;
      5'd4:  r = 17'd4091;
      5'd5:  r = 17'd2047;
      5'd6:  r = 17'd1024;
      5'd7:  r = 17'd512;
      5'd8:  r = 17'd256;
      5'd9:  r = 17'd128;
      5'd10: r = 17'd64;
      5'd11: r = 17'd32;
      5'd12: r = 17'd16;
      5'd13: r = 17'd8;
      5'd14: r = 17'd4;
      5'd15: r = 17'd2;
      5'd16: r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[design/right_wall_follow_controller.sv]
// Top level of the right-wall follow drive controller.
// Input stream s_*: tuser is the item kind (0 scan, 1 command); tdata carries the
// time and the three sector readings with their valid flags. A scan is stored
// and gives no result. A command gives one drive transaction on m_*.
// Stop, turn-left and find-wall commands go straight to the output state. A follow command
// runs through one shared 32x32 multiplier, a bit-serial square root, a shared restoring
// divider (used up to twice) and a CORDIC of at most CORDIC_STEPS and at most ATAN_ENTRIES
// iterations; when the diagonal sees an opening, the square root, the first division and
// the CORDIC are skipped. s_tready is low until the result is registered.
// A finished result waits in the output register; a new item is taken while it
// waits, and the next command holds at its end until m_tready takes the old one.
// Configuration writes on cfg_* take effect at once and should be made while idle.
// Reset (rst, synchronous) restores the default registers, clears the stored scan
// and returns the drive mode to waiting.
`timescale 1ns / 1ps
`default_nettype none
module right_wall_follow_controller
  import rwf_pkg::*;
#(
  parameter int SEARCH_SPEED      = SEARCH_SPEED_DEF,
  parameter int SEARCH_TURN_SPEED = SEARCH_TURN_SPEED_DEF,
  parameter int SCAN_TIMEOUT_MS   = SCAN_TIMEOUT_MS_DEF,
  parameter int CORDIC_STEPS      = CORDIC_STEPS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // now_ms[31:0], front_mm[47:32], right_mm[63:48], diagonal_mm[79:64],
  // front_ok[80], right_ok[81], diagonal_ok[82], zero fill
  input  wire logic [87:0]  s_tdata,
  // req_type
  input  wire logic         s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // linear_mm_s[11:0], angular_mrad_s[25:12], zero fill
  output logic [31:0]       m_tdata,
  // mode
  output logic [1:0]        m_tuser,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);

  localparam int NSTEP = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

  typedef enum logic [4:0] {
    S_IDLE, S_SQX, S_SQY, S_SQSUM, S_SQRT, S_NUM, S_DIVA_GO, S_DIVA_WAIT,
    S_CORD, S_MERR, S_MANG, S_MHG, S_SUM, S_MLIN, S_DIVB_GO, S_DIVB_WAIT, S_FIN
  } state_t;

  state_t state;

  logic [15:0] wall_distance, front_stop, front_release, lost_wall;
  logic [11:0] forward_speed;
  logic [12:0] turn_speed;
  logic [15:0] distance_gain, heading_gain;

  logic [15:0] front_dist, right_dist, diag_dist;
  logic        scan_valid;
  logic [31:0] last_scan_time;
  logic [1:0]  drive_mode;

  logic [27:0]        x0;
  logic signed [33:0] cx, cy;
  logic signed [19:0] cz;
  logic [4:0]         step;
  logic [59:0]        sq_v, sq_res, sq_bit;
  logic [30:0]        h_r;
  logic [24:0]        dist_q8;
  logic signed [63:0] acc;
  logic signed [13:0] ang;
  logic [11:0]        lin;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;

  div_req_t div_req;
  div_rsp_t div_rsp;

  rwf_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  logic        [31:0] now;
  logic               stale;
  logic signed [33:0] y_init;
  logic        [29:0] y_abs;
  logic        [59:0] sq_trial;
  logic signed [25:0] err;
  logic signed [63:0] sum;
  logic signed [39:0] ang_raw;
  logic signed [40:0] t_s;
  logic        [12:0] mag;
  logic        [13:0] lin_factor;
  logic signed [33:0] cdx, cdy;

  always_comb begin
    now      = s_tdata[31:0];
    stale    = !scan_valid || (now < last_scan_time) ||
               ((now - last_scan_time) > 32'(SCAN_TIMEOUT_MS));
    y_init   = 34'(signed'({1'b0, diag_dist, 12'd0})) -
               34'(signed'({1'b0, 30'(right_dist * 30'(SQRT2_Q12))}));
    y_abs    = cy[33] ? 30'(-cy) : 30'(cy);
    sq_trial = sq_res + sq_bit;
    err      = 26'(signed'({2'b0, wall_distance, 8'd0})) - 26'(signed'({1'b0, dist_q8}));
    sum      = acc - prod;
    ang_raw  = 40'((sum + 64'sd8388608) >>> 24);
    t_s      = 41'(signed'({1'b0, turn_speed}));
    mag      = ang[13] ? 13'(-ang) : 13'(ang);
    lin_factor = {turn_speed, 1'b0} - {1'b0, mag};
    cdx      = cy >>> step;
    cdy      = cx >>> step;
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQX: begin
        mul_a = 32'(x0);
        mul_b = 32'(x0);
      end
      S_SQY: begin
        mul_a = 32'(y_abs);
        mul_b = 32'(y_abs);
      end
      S_NUM: begin
        mul_a = 32'(right_dist);
        mul_b = 32'(x0);
      end
      S_MERR: begin
        mul_a = 32'(distance_gain);
        mul_b = 32'(err);
      end
      S_MANG: begin
        mul_a = 32'(cz);
        mul_b = 32'sd1000;
      end
      S_MHG: begin
        mul_a = 32'(heading_gain);
        mul_b = prod[31:0];
      end
      S_MLIN: begin
        mul_a = 32'(forward_speed);
        mul_b = 32'(lin_factor);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    if (state == S_DIVA_GO && h_r != '0) begin
      div_req.start = 1'b1;
      div_req.num   = 53'({prod[44:0], 8'd0}) + 53'(h_r >> 1);
      div_req.den   = h_r;
    end else if (state == S_DIVB_GO && turn_speed != '0) begin
      div_req.start = 1'b1;
      div_req.num   = 53'(prod[26:0]) + 53'(turn_speed);
      div_req.den   = 31'({turn_speed, 1'b0});
    end
  end

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      wall_distance  <= 16'd500;
      front_stop     <= 16'd400;
      front_release  <= 16'd600;
      lost_wall      <= 16'd1000;
      forward_speed  <= 12'd200;
      turn_speed     <= 13'd1000;
      distance_gain  <= 16'd512;
      heading_gain   <= 16'd256;
      front_dist     <= '0;
      right_dist     <= '0;
      diag_dist      <= '0;
      scan_valid     <= 1'b0;
      last_scan_time <= '0;
      drive_mode     <= MODE_WAIT;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WALL_DISTANCE: wall_distance <= cfg_data;
          REG_FRONT_STOP:    front_stop    <= cfg_data;
          REG_FRONT_RELEASE: front_release <= cfg_data;
          REG_LOST_WALL:     lost_wall     <= cfg_data;
          REG_FORWARD_SPEED: forward_speed <= cfg_data[11:0];
          REG_TURN_SPEED:    turn_speed    <= cfg_data[12:0];
          REG_DISTANCE_GAIN: distance_gain <= cfg_data;
          REG_HEADING_GAIN:  heading_gain  <= cfg_data;
          default: ;
        endcase
      end
      // In S_FIN an accepted result is replaced by the new one below.
      if (m_tvalid && m_tready && state != S_FIN) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (!s_tuser) begin
              front_dist     <= s_tdata[47:32];
              right_dist     <= s_tdata[63:48];
              diag_dist      <= s_tdata[79:64];
              scan_valid     <= &s_tdata[82:80];
              last_scan_time <= now;
              if (!(&s_tdata[82:80])) begin
                drive_mode <= MODE_WAIT;
              end
            end else if (stale) begin
              drive_mode <= MODE_WAIT;
              lin        <= '0;
              ang        <= '0;
              state      <= S_FIN;
            end else if (front_dist < front_stop ||
                         (drive_mode == MODE_TURN && front_dist < front_release)) begin
              drive_mode <= MODE_TURN;
              lin        <= '0;
              ang        <= 14'(signed'({1'b0, turn_speed}));
              state      <= S_FIN;
            end else if (right_dist > lost_wall) begin
              drive_mode <= MODE_FIND;
              lin        <= 12'(SEARCH_SPEED);
              ang        <= -14'(SEARCH_TURN_SPEED);
              state      <= S_FIN;
            end else begin
              drive_mode <= MODE_FOLLOW;
              x0         <= {diag_dist, 12'd0};
              cx         <= 34'(signed'({1'b0, diag_dist, 12'd0}));
              cy         <= y_init;
              cz         <= '0;
              step       <= '0;
              dist_q8    <= {1'b0, right_dist, 8'd0};
              // An opening on the diagonal leaves angle zero and the raw distance.
              if ({1'b0, diag_dist, 1'b0} >= 18'(lost_wall * 18'd3)) begin
                state <= S_MERR;
              end else begin
                state <= S_SQX;
              end
            end
          end
        end
        S_SQX: state <= S_SQY;
        S_SQY: begin
          acc   <= prod;
          state <= S_SQSUM;
        end
        S_SQSUM: begin
          sq_v   <= 60'(acc) + 60'(prod);
          sq_res <= '0;
          sq_bit <= 60'd1 << 58;
          state  <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_v >= sq_trial) begin
            sq_v   <= sq_v - sq_trial;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) begin
            state <= S_NUM;
          end
        end
        S_NUM: begin
          h_r   <= sq_res[30:0];
          state <= S_DIVA_GO;
        end
        S_DIVA_GO: begin
          state <= (h_r == '0) ? S_CORD : S_DIVA_WAIT;
        end
        S_DIVA_WAIT: begin
          if (div_rsp.done) begin
            dist_q8 <= div_rsp.quot[24:0];
            state   <= S_CORD;
          end
        end
        S_CORD: begin
          if (step == '0 && cy == '0) begin
            state <= S_MERR;
          end else begin
            if (!cy[33]) begin
              cx <= cx + cdx;
              cy <= cy - cdy;
              cz <= cz + 20'(atan_q16(step));
            end else begin
              cx <= cx - cdx;
              cy <= cy + cdy;
              cz <= cz - 20'(atan_q16(step));
            end
            step <= step + 1'b1;
            if (step == 5'(NSTEP - 1)) begin
              state <= S_MERR;
            end
          end
        end
        S_MERR: state <= S_MANG;
        S_MANG: begin
          acc   <= prod <<< 8;
          state <= S_MHG;
        end
        S_MHG: state <= S_SUM;
        S_SUM: begin
          if (41'(ang_raw) > t_s) begin
            ang <= 14'(t_s);
          end else if (41'(ang_raw) < -t_s) begin
            ang <= 14'(-t_s);
          end else begin
            ang <= 14'(ang_raw);
          end
          state <= S_MLIN;
        end
        S_MLIN: state <= S_DIVB_GO;
        S_DIVB_GO: begin
          if (turn_speed == '0) begin
            lin   <= forward_speed;
            state <= S_FIN;
          end else begin
            state <= S_DIVB_WAIT;
          end
        end
        S_DIVB_WAIT: begin
          if (div_rsp.done) begin
            lin   <= div_rsp.quot[11:0];
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'd0, ang, lin};
            m_tuser  <= drive_mode;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_turn_no_linear: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == MODE_TURN |-> m_tdata[11:0] == 12'd0)
    else $error("turn result carries forward speed");
  a_wait_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == MODE_WAIT |-> m_tdata[25:0] == 26'd0)
    else $error("waiting result is not a full stop");
  a_find_cmd: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == MODE_FIND |->
      m_tdata[25:12] == -14'(SEARCH_TURN_SPEED) && m_tdata[11:0] == 12'(SEARCH_SPEED))
    else $error("find-wall result differs from search drive");
  a_busy_div: assert property (@(posedge clk) disable iff (rst)
    state == S_DIVA_GO && h_r != '0 |=> state == S_DIVA_WAIT && !s_tready)
    else $error("divider launch did not hold the sequencer");
`endif

endmodule
`default_nettype wire

[design/rwf_divider.sv]
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rwf_divider
  import rwf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int CW = $clog2(DIV_NW + 1);

  logic              busy;
  logic              done;
  logic [CW-1:0]     cnt;
  logic [DIV_NW-1:0] n;
  logic [DIV_DW:0]   rem;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_DW:0]   rem_sh;
  logic              ge;
  logic [DIV_DW:0]   rem_next;

  always_comb begin
    rem_sh   = {rem[DIV_DW-1:0], n[DIV_NW-1]};
    ge       = rem_sh >= {1'b0, den_r};
    rem_next = ge ? rem_sh - {1'b0, den_r} : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        n     <= req.num;
        rem   <= '0;
        den_r <= req.den;
        cnt   <= '0;
      end else if (busy) begin
        n   <= {n[DIV_NW-2:0], ge};
        rem <= rem_next;
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DIV_NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = n;

endmodule
`default_nettype wire
